// ----- hdl/bsfr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bsfr_pkg;

  localparam int STORE_DEPTH = 512;
  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int IDX_W = 9;
  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int LEN_W = 10;
  localparam int BYTE_W = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic OP_RECV = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FLAG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK = 2'd2;

  localparam logic [BYTE_W-1:0] FLAG_RESET = 8'd126;
  localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd125;
  localparam logic [BYTE_W-1:0] MASK_RESET = 8'd32;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_DONE     = 2'd1,
    EV_OVERFLOW = 2'd2,
    EV_READ     = 2'd3
  } event_kind_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    event_kind_t      kind;
    logic [CNT_W-1:0] len;
    logic             rd_hit;
  } result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] flag;
    logic [BYTE_W-1:0] escape;
    logic [BYTE_W-1:0] mask;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hdl/bsfr_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bsfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/bsfr_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bsfr_ctrl (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               accept,
  input  wire logic                               op,
  input  wire logic [bsfr_pkg::BYTE_W-1:0]        line_byte,
  input  wire logic [bsfr_pkg::IDX_W-1:0]         read_index,
  input  wire bsfr_pkg::cfg_t                     cfg,
  output bsfr_pkg::wr_req_t                       wr,
  output bsfr_pkg::rd_req_t                       rd,
  output bsfr_pkg::result_t                       res
);

  import bsfr_pkg::*;

  logic             inside_frame, inside_frame_next;
  logic             escape_pending, escape_pending_next;
  logic [CNT_W-1:0] stored_count, stored_count_next;

  logic [BYTE_W-1:0] data_byte;
  logic [CMP_W-1:0]  idx_ext, cnt_ext;
  logic              store;

  assign idx_ext = CMP_W'(read_index);
  assign cnt_ext = CMP_W'(stored_count);

  always_comb begin
    inside_frame_next   = inside_frame;
    escape_pending_next = escape_pending;
    stored_count_next   = stored_count;
    data_byte           = line_byte;
    store               = 1'b0;
    res.kind            = EV_NONE;
    res.len             = '0;
    res.rd_hit          = 1'b0;
    rd.re               = 1'b0;
    rd.addr             = ADDR_W'(read_index);

    if (op == OP_READ) begin
      res.kind   = EV_READ;
      res.rd_hit = idx_ext < cnt_ext;
      rd.re      = accept;
    end else if (line_byte == cfg.flag) begin
      // flag wins over escape handling
      if (inside_frame && stored_count != '0) begin
        inside_frame_next = 1'b0;
        res.kind          = EV_DONE;
        res.len           = stored_count;
      end else begin
        inside_frame_next   = 1'b1;
        stored_count_next   = '0;
        escape_pending_next = 1'b0;
      end
    end else if (inside_frame) begin
      if (escape_pending) begin
        data_byte           = line_byte ^ cfg.mask;
        escape_pending_next = 1'b0;
        store               = 1'b1;
      end else if (line_byte == cfg.escape) begin
        escape_pending_next = 1'b1;
      end else begin
        store = 1'b1;
      end
      if (store) begin
        if (stored_count != CNT_W'(STORE_DEPTH)) begin
          stored_count_next = stored_count + CNT_W'(1);
        end else begin
          store             = 1'b0;
          stored_count_next = '0;
          inside_frame_next = 1'b0;
          res.kind          = EV_OVERFLOW;
        end
      end
    end
  end

  // write goes to the slot past the last valid byte; reads only hit lower slots
  assign wr.we   = accept && store;
  assign wr.addr = stored_count[ADDR_W-1:0];
  assign wr.data = data_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_frame   <= 1'b0;
      escape_pending <= 1'b0;
      stored_count   <= '0;
    end else if (accept) begin
      inside_frame   <= inside_frame_next;
      escape_pending <= escape_pending_next;
      stored_count   <= stored_count_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/byte_stuffed_frame_receiver.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel  | handshake            | payload
// ---------+----------------------+------------------------------------------
// in       | in_valid / in_ready  | op, line_byte, read_index
// out      | out_valid / out_ready| event_kind, frame_bytes, read_byte
// cfg      | cfg_we               | cfg_index, cfg_data
//
// One request per cycle unless a result is stalled; each result appears the cycle after its request.
// Stored bytes live in a single-port-write RAM; read data comes from its
// registered read port in the next cycle, in step with the registered result.
// Reset clears framing state and out_valid and restores the config defaults; the frame store is not cleared.
// While a result waits on out_ready, in_ready is low and nothing advances.
module byte_stuffed_frame_receiver (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                op,
  input  wire logic [bsfr_pkg::BYTE_W-1:0]         line_byte,
  input  wire logic [bsfr_pkg::IDX_W-1:0]          read_index,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [1:0]                          event_kind,
  output logic      [bsfr_pkg::LEN_W-1:0]          frame_bytes,
  output logic      [bsfr_pkg::BYTE_W-1:0]         read_byte,
  input  wire logic                                cfg_we,
  input  wire logic [bsfr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bsfr_pkg::BYTE_W-1:0]         cfg_data
);

  import bsfr_pkg::*;

  cfg_t              cfg;
  wr_req_t           wr;
  rd_req_t           rd;
  result_t           res;
  result_t           held;
  logic              accept;
  logic [BYTE_W-1:0] ram_rdata;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flag   <= FLAG_RESET;
      cfg.escape <= ESCAPE_RESET;
      cfg.mask   <= MASK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FLAG:   cfg.flag   <= cfg_data;
        CFG_ESCAPE: cfg.escape <= cfg_data;
        CFG_MASK:   cfg.mask   <= cfg_data;
        default:    ;
      endcase
    end
  end

  bsfr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .op         (op),
    .line_byte  (line_byte),
    .read_index (read_index),
    .cfg        (cfg),
    .wr         (wr),
    .rd         (rd),
    .res        (res)
  );

  bsfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd.re),
    .raddr (rd.addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= res;
    end
  end

  // RAM read port only moves on an accepted read, so rdata holds during a stall
  assign event_kind  = held.kind;
  assign frame_bytes = (held.kind == EV_DONE) ? LEN_W'(held.len) : '0;
  assign read_byte   = (held.kind == EV_READ && held.rd_hit) ? ram_rdata : '0;

  a_read_follows: assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_READ) |=> (out_valid && event_kind == EV_READ))
    else $error("read request did not yield a read result");

  a_write_only_on_recv: assert property (@(posedge clk) disable iff (rst)
    wr.we |-> (accept && op == OP_RECV))
    else $error("store write without an accepted line byte");

  a_done_has_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind == EV_DONE) |-> (held.len != '0))
    else $error("frame complete reported with zero length");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(event_kind)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// ----- verif/deframe_checker.sv -----
`timescale 1ns / 1ps

module deframe_checker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  input  wire logic                           in_ready,
  input  wire logic                           op,
  input  wire logic [bsfr_pkg::BYTE_W-1:0]    line_byte,
  input  wire logic [bsfr_pkg::IDX_W-1:0]     read_index,
  input  wire logic                           out_valid,
  input  wire logic                           out_ready,
  input  wire logic [1:0]                     event_kind,
  input  wire logic [bsfr_pkg::LEN_W-1:0]     frame_bytes,
  input  wire logic [bsfr_pkg::BYTE_W-1:0]    read_byte,
  input  wire logic                           cfg_we,
  input  wire logic [bsfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bsfr_pkg::BYTE_W-1:0]    cfg_data,
  output int                                  errors,
  output int                                  outstanding
);

  import bsfr_pkg::*;

  typedef struct packed {
    event_kind_t       kind;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] data;
  } frame_event_t;

  logic [BYTE_W-1:0] flag_q;
  logic [BYTE_W-1:0] esc_q;
  logic [BYTE_W-1:0] mask_q;
  logic              in_frame;
  logic              esc_pending;
  logic [CNT_W-1:0]  rx_count;
  logic [BYTE_W-1:0] rx_store [STORE_DEPTH];

  frame_event_t      pending_events [$];
  frame_event_t      want;

  initial errors = 0;
  initial outstanding = 0;

  function automatic frame_event_t deframe_step(input logic rd, input logic [BYTE_W-1:0] b,
                                                input logic [IDX_W-1:0] idx);
    frame_event_t ev;
    logic [BYTE_W-1:0] v;
    logic keep;
    ev.kind = EV_NONE;
    ev.len = '0;
    ev.data = '0;
    v = b;
    if (rd == OP_READ) begin
      ev.kind = EV_READ;
      if (idx < rx_count) ev.data = rx_store[idx];
    end else if (v == flag_q) begin
      // flag beats a pending escape; it closes only a frame that holds data
      if (in_frame && rx_count != '0) begin
        in_frame = 1'b0;
        ev.kind = EV_DONE;
        ev.len = rx_count;
      end else begin
        in_frame = 1'b1;
        rx_count = '0;
        esc_pending = 1'b0;
      end
    end else if (in_frame) begin
      keep = 1'b1;
      if (esc_pending) begin
        v = v ^ mask_q;
        esc_pending = 1'b0;
      end else if (v == esc_q) begin
        esc_pending = 1'b1;
        keep = 1'b0;
      end
      if (keep) begin
        if (rx_count < CNT_W'(STORE_DEPTH)) begin
          rx_store[rx_count[ADDR_W-1:0]] = v;
          rx_count = rx_count + CNT_W'(1);
        end else begin
          rx_count = '0;
          in_frame = 1'b0;
          ev.kind = EV_OVERFLOW;
        end
      end
    end
    return ev;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      flag_q = FLAG_RESET;
      esc_q = ESCAPE_RESET;
      mask_q = MASK_RESET;
      in_frame = 1'b0;
      esc_pending = 1'b0;
      rx_count = '0;
      pending_events.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_events.size() == 0) begin
          errors++;
          $display("%0t: result with no request waiting: kind=%0d len=%0d byte=0x%02h",
                   $time, event_kind, frame_bytes, read_byte);
        end else begin
          want = pending_events.pop_front();
          if (event_kind !== want.kind || frame_bytes !== want.len ||
              read_byte !== want.data) begin
            errors++;
            $display("%0t: mismatch: expected kind=%0d len=%0d byte=0x%02h", $time,
                     want.kind, want.len, want.data);
            $display("%0t:           actual kind=%0d len=%0d byte=0x%02h", $time,
                     event_kind, frame_bytes, read_byte);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_FLAG:   flag_q = cfg_data;
          CFG_ESCAPE: esc_q = cfg_data;
          CFG_MASK:   mask_q = cfg_data;
          default:    ;
        endcase
      end
      if (in_valid && in_ready) pending_events.push_back(deframe_step(op, line_byte, read_index));
    end
    outstanding <= pending_events.size();
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import bsfr_pkg::*;

  localparam int STUCK_LIMIT = 2000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 op = OP_RECV;
  logic [BYTE_W-1:0]    line_byte = '0;
  logic [IDX_W-1:0]     read_index = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FLAG;
  logic [BYTE_W-1:0]    cfg_data = '0;

  wire logic              in_ready;
  wire logic              out_valid;
  wire logic [1:0]        event_kind;
  wire logic [LEN_W-1:0]  frame_bytes;
  wire logic [BYTE_W-1:0] read_byte;

  int errors;
  int outstanding;
  int stuck = 0;
  int items = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // what the stimulus believes the registers hold
  logic [BYTE_W-1:0] cur_flag = FLAG_RESET;
  logic [BYTE_W-1:0] cur_esc = ESCAPE_RESET;
  logic [BYTE_W-1:0] cur_mask = MASK_RESET;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  byte_stuffed_frame_receiver u_top (
    .clk, .rst, .in_valid, .in_ready, .op, .line_byte, .read_index,
    .out_valid, .out_ready, .event_kind, .frame_bytes, .read_byte,
    .cfg_we, .cfg_index, .cfg_data
  );

  deframe_checker u_checker (
    .clk, .rst, .in_valid, .in_ready, .op, .line_byte, .read_index,
    .out_valid, .out_ready, .event_kind, .frame_bytes, .read_byte,
    .cfg_we, .cfg_index, .cfg_data, .errors, .outstanding
  );

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck <= 0;
    end else if (stuck >= STUCK_LIMIT) begin
      $display("byte_stuffed_frame_receiver regression: fail");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  task automatic send(input logic o, input logic [BYTE_W-1:0] b, input logic [IDX_W-1:0] idx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    line_byte <= b;
    read_index <= idx;
    do @(posedge clk); while (!in_ready);
    items++;
  endtask

  task automatic recv_byte(input logic [BYTE_W-1:0] b);
    send(OP_RECV, b, 9'($urandom_range(0, 511)));
  endtask

  task automatic read_at(input logic [IDX_W-1:0] idx);
    send(OP_READ, 8'($urandom_range(0, 255)), idx);
  endtask

  // hold off new requests until every result is back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_config(input logic [BYTE_W-1:0] f, input logic [BYTE_W-1:0] e,
                             input logic [BYTE_W-1:0] m);
    cfg_we <= 1'b1;
    cfg_index <= CFG_FLAG;
    cfg_data <= f;
    @(posedge clk);
    cfg_index <= CFG_ESCAPE;
    cfg_data <= e;
    @(posedge clk);
    cfg_index <= CFG_MASK;
    cfg_data <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_flag = f;
    cur_esc = e;
    cur_mask = m;
  endtask

  function automatic logic [BYTE_W-1:0] frame_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return cur_esc;
    if (r < 9) return cur_flag;              // stray flag cuts the frame short
    if (r < 12) return cur_flag ^ cur_mask;
    if (r < 15) return cur_esc ^ cur_mask;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == cur_flag || b == cur_esc) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic random_frame(input int max_len);
    int n;
    n = $urandom_range(1, max_len);
    if ($urandom_range(0, 4) == 0) recv_byte(8'($urandom_range(0, 255)));
    recv_byte(cur_flag);
    if ($urandom_range(0, 5) == 0) recv_byte(cur_flag);
    repeat (n) recv_byte(frame_byte());
    if ($urandom_range(0, 7) != 0) recv_byte(cur_flag);
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 7) != 0) read_at(9'($urandom_range(0, n)));
      else read_at(9'($urandom_range(0, 511)));
    end
  endtask

  task automatic burst(input int count);
    int start;
    start = items;
    while (items - start < count) begin
      random_frame(($urandom_range(0, 9) == 0) ? 64 : 16);
      if ($urandom_range(0, 39) == 0) settle();
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] f;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings, no idling
    read_at(0);
    read_at(511);
    recv_byte(8'h00);
    recv_byte(cur_flag);
    recv_byte(cur_flag);
    recv_byte(8'h00);
    recv_byte(8'hFF);
    recv_byte(cur_esc);
    recv_byte(cur_esc ^ cur_mask);
    recv_byte(cur_esc);
    recv_byte(cur_esc);
    recv_byte(cur_esc);
    recv_byte(cur_flag);                     // closes with an escape still pending
    read_at(0);
    read_at(3);
    read_at(4);
    recv_byte(cur_flag);
    recv_byte(cur_esc);
    recv_byte(cur_flag);                     // empty frame restart drops the escape
    recv_byte(cur_mask);
    recv_byte(cur_flag);
    read_at(0);
    burst(20);
    settle();

    load_config(8'h00, 8'hFF, 8'hFF);
    send_idle_pct = 57;
    burst(12);
    settle();
    burst(12);
    settle();

    load_config(8'hFF, 8'h00, 8'h00);
    send_idle_pct = 0;
    recv_stall_pct = 57;
    burst(20);
    settle();

    // flag and escape share a value: the flag meaning wins
    f = 8'($urandom_range(0, 255));
    load_config(f, f, 8'($urandom_range(0, 255)));
    send_idle_pct = 20;
    recv_stall_pct = 20;
    burst(20);
    settle();

    // fill the store, then overrun it with an escaped byte
    f = 8'($urandom_range(0, 255));
    load_config(f, f ^ 8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)));
    recv_byte(cur_flag);
    repeat (STORE_DEPTH) recv_byte(plain_byte());
    read_at(9'(STORE_DEPTH - 1));
    read_at(0);
    recv_byte(cur_esc);                      // a full store still takes the escape
    recv_byte(plain_byte());
    read_at(0);
    recv_byte(plain_byte());
    settle();

    if (errors == 0) begin
      $display("byte_stuffed_frame_receiver regression: pass");
    end else begin
      $display("byte_stuffed_frame_receiver regression: fail");
    end
    $finish;
  end

endmodule

// ----- byte_stuffed_frame_receiver.f -----
hdl/bsfr_pkg.sv
hdl/bsfr_ram.sv
hdl/bsfr_ctrl.sv
hdl/byte_stuffed_frame_receiver.sv
verif/deframe_checker.sv
verif/testbench.sv
